// ===== src/nlp_pkg.sv =====
// nlp_pkg: shared constants, codes and types for the permutation engine
// no dependencies; used by nlp_cell, next_lexicographic_permutation, nlp_checker and testbench
package nlp_pkg;

    localparam int MAX_LEN  = 16;
    localparam int EMIT_MAX = 16;
    localparam int EMIT_CAP = (MAX_LEN < EMIT_MAX) ? MAX_LEN : EMIT_MAX;
    localparam int SYM_W    = 8;
    localparam int FUNC_W   = 2;
    localparam int POS_W    = 4;
    localparam int IDX_W    = $clog2(MAX_LEN);
    localparam int LEN_W    = $clog2(MAX_LEN + 1);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_SORT   = 2'd2,
        FUNC_NEXT   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_RIGHT,
        CELL_FROM_LEFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t             op;
        logic [SYM_W-1:0]     load_val;
    } cell_ctl_t;

    typedef struct packed {
        logic gt_right;
        logic lt_right;
        logic gt_pivot;
    } cell_flags_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_PICK,
        ST_SORT,
        ST_EMIT,
        ST_RESTORE,
        ST_SINGLE
    } state_t;

endpackage

// ===== src/nlp_cell.sv =====
// nlp_cell: one byte of the ring, with local compares against its right
// neighbor and the broadcast pivot; depends on nlp_pkg
module nlp_cell (
    input  logic                      aclk,
    input  nlp_pkg::cell_ctl_t        ctl,
    input  logic [nlp_pkg::SYM_W-1:0] left_val,
    input  logic [nlp_pkg::SYM_W-1:0] right_val,
    input  logic [nlp_pkg::SYM_W-1:0] pivot_val,
    output logic [nlp_pkg::SYM_W-1:0] value,
    output nlp_pkg::cell_flags_t      flags
);

    logic [nlp_pkg::SYM_W-1:0] value_reg;
    logic [nlp_pkg::SYM_W-1:0] value_next;

    always_comb begin
        unique case (ctl.op)
            nlp_pkg::CELL_HOLD:       value_next = value_reg;
            nlp_pkg::CELL_LOAD:       value_next = ctl.load_val;
            nlp_pkg::CELL_FROM_RIGHT: value_next = right_val;
            nlp_pkg::CELL_FROM_LEFT:  value_next = left_val;
            default:                  value_next = value_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value          = value_reg;
    assign flags.gt_right = value_reg > right_val;
    assign flags.lt_right = value_reg < right_val;
    assign flags.gt_pivot = value_reg > pivot_val;

endmodule

// ===== src/next_lexicographic_permutation.sv =====
// Next lexicographic permutation engine: holds a byte string of up to MAX_LEN bytes in a ring
// of cells. Clear and append finish on accept, staying idle. Sort runs MAX_LEN odd-even
// transposition passes over the ring, then emits min(length, 16) beats from cell zero, one
// per cycle while the output does not stall, as the ring rotates, then keeps rotating until
// MAX_LEN rotations in all have put the string back in place; an empty string gets a single
// empty beat instead. Next finds the pivot, then swaps in its successor, ahead of the passes
// and only sorts the suffix; at the last permutation, or with fewer than two bytes, it
// answers with a single done beat. The pass count and the ring rotation set the rate.
// depends on nlp_pkg and nlp_cell
module next_lexicographic_permutation (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [nlp_pkg::FUNC_W-1:0] s_func,
    input  logic [nlp_pkg::SYM_W-1:0]  s_symbol_in,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [nlp_pkg::SYM_W-1:0]  m_symbol_out,
    output logic [nlp_pkg::POS_W-1:0]  m_position,
    output logic                       m_is_last,
    output logic                       m_done_res,
    output logic                       m_string_empty,
    output logic                       m_overflowed
);

    localparam int N = nlp_pkg::MAX_LEN;
    localparam int LW = nlp_pkg::LEN_W;
    localparam int IW = nlp_pkg::IDX_W;
    localparam int SW = nlp_pkg::SYM_W;

    nlp_pkg::state_t state_reg, state_next;
    logic [LW-1:0] len_reg, len_next;
    logic          ovf_reg, ovf_next;
    logic [IW-1:0] piv_reg, piv_next;
    logic [SW-1:0] pval_reg, pval_next;
    logic [LW-1:0] from_reg, from_next;
    logic [IW-1:0] pass_reg, pass_next;
    logic [LW-1:0] cnt_reg, cnt_next;
    logic          sdone_reg, sdone_next;

    logic                         m_valid_reg, m_valid_next;
    logic [SW-1:0]                m_sym_reg, m_sym_next;
    logic [nlp_pkg::POS_W-1:0]    m_pos_reg, m_pos_next;
    logic                         m_last_reg, m_last_next;
    logic                         m_done_reg, m_done_next;
    logic                         m_empty_reg, m_empty_next;
    logic                         m_ovf_reg, m_ovf_next;

    nlp_pkg::cell_ctl_t   cell_ctl [N];
    logic [SW-1:0]        cell_val [N];
    nlp_pkg::cell_flags_t flags    [N];

    logic [N-1:0]  rise, rsel, cand, jsel, swap;
    logic          rfound, jfound;
    logic [IW-1:0] rise_idx;
    logic [SW-1:0] rise_val, jval;
    logic [LW-1:0] nemit, cnt_inc;
    logic          out_free, s_fire;

    // ring of cells, last cell wraps to the first
    for (genvar g = 0; g < N; g++) begin : g_cell
        nlp_cell u_cell (
            .aclk      (aclk),
            .ctl       (cell_ctl[g]),
            .left_val  (cell_val[(g + N - 1) % N]),
            .right_val (cell_val[(g + 1) % N]),
            .pivot_val (pval_reg),
            .value     (cell_val[g]),
            .flags     (flags[g])
        );
    end

    assign s_ready  = (state_reg == nlp_pkg::ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign nemit    = (len_reg > LW'(nlp_pkg::EMIT_CAP)) ? LW'(nlp_pkg::EMIT_CAP) : len_reg;
    assign cnt_inc  = cnt_reg + LW'(1);

    // rightmost rise and rightmost byte above the pivot, as one-hot picks
    always_comb begin
        rfound   = 1'b0;
        jfound   = 1'b0;
        rise_idx = '0;
        rise_val = '0;
        jval     = '0;
        for (int k = 0; k < N; k++) begin
            rise[k] = flags[k].lt_right && (LW'(k + 1) < len_reg);
            cand[k] = flags[k].gt_pivot && (IW'(k) > piv_reg) && (LW'(k) < len_reg);
            swap[k] = 1'b0;
        end
        for (int k = N - 1; k >= 0; k--) begin
            rsel[k] = rise[k] && !rfound;
            rfound  = rfound || rise[k];
            jsel[k] = cand[k] && !jfound;
            jfound  = jfound || cand[k];
        end
        for (int k = 0; k < N; k++) begin
            if (rsel[k]) begin
                rise_idx = rise_idx | IW'(k);
                rise_val = rise_val | cell_val[k];
            end
            if (jsel[k]) begin
                jval = jval | cell_val[k];
            end
        end
        for (int k = 0; k < N - 1; k++) begin
            swap[k] = (1'(k) == pass_reg[0]) && (LW'(k) >= from_reg)
                      && (LW'(k + 1) < len_reg) && flags[k].gt_right;
        end
    end

    always_comb begin
        state_next   = state_reg;
        len_next     = len_reg;
        ovf_next     = ovf_reg;
        piv_next     = piv_reg;
        pval_next    = pval_reg;
        from_next    = from_reg;
        pass_next    = pass_reg;
        cnt_next     = cnt_reg;
        sdone_next   = sdone_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_sym_next   = m_sym_reg;
        m_pos_next   = m_pos_reg;
        m_last_next  = m_last_reg;
        m_done_next  = m_done_reg;
        m_empty_next = m_empty_reg;
        m_ovf_next   = m_ovf_reg;
        for (int k = 0; k < N; k++) begin
            cell_ctl[k].op       = nlp_pkg::CELL_HOLD;
            cell_ctl[k].load_val = s_symbol_in;
        end

        unique case (state_reg)
            nlp_pkg::ST_IDLE: begin
                if (s_fire) begin
                    unique case (nlp_pkg::func_t'(s_func))
                        nlp_pkg::FUNC_CLEAR: begin
                            len_next = '0;
                            ovf_next = 1'b0;
                        end
                        nlp_pkg::FUNC_APPEND: begin
                            if (len_reg < LW'(N)) begin
                                for (int k = 0; k < N; k++) begin
                                    if (LW'(k) == len_reg) begin
                                        cell_ctl[k].op = nlp_pkg::CELL_LOAD;
                                    end
                                end
                                len_next = len_reg + LW'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        nlp_pkg::FUNC_SORT: begin
                            from_next  = '0;
                            pass_next  = '0;
                            state_next = nlp_pkg::ST_SORT;
                        end
                        nlp_pkg::FUNC_NEXT: begin
                            if (len_reg < LW'(2)) begin
                                sdone_next = 1'b1;
                                state_next = nlp_pkg::ST_SINGLE;
                            end else begin
                                state_next = nlp_pkg::ST_FIND;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            nlp_pkg::ST_FIND: begin
                if (rfound) begin
                    piv_next   = rise_idx;
                    pval_next  = rise_val;
                    state_next = nlp_pkg::ST_PICK;
                end else begin
                    sdone_next = 1'b1;
                    state_next = nlp_pkg::ST_SINGLE;
                end
            end
            nlp_pkg::ST_PICK: begin
                // swap pivot with its successor, suffix gets sorted next
                for (int k = 0; k < N; k++) begin
                    if (jsel[k]) begin
                        cell_ctl[k].op       = nlp_pkg::CELL_LOAD;
                        cell_ctl[k].load_val = pval_reg;
                    end else if (IW'(k) == piv_reg) begin
                        cell_ctl[k].op       = nlp_pkg::CELL_LOAD;
                        cell_ctl[k].load_val = jval;
                    end
                end
                from_next  = LW'(piv_reg) + LW'(1);
                pass_next  = '0;
                state_next = nlp_pkg::ST_SORT;
            end
            nlp_pkg::ST_SORT: begin
                for (int k = 0; k < N; k++) begin
                    if (k < N - 1 && swap[k]) begin
                        cell_ctl[k].op = nlp_pkg::CELL_FROM_RIGHT;
                    end else if (k > 0 && swap[(k + N - 1) % N]) begin
                        cell_ctl[k].op = nlp_pkg::CELL_FROM_LEFT;
                    end
                end
                pass_next = pass_reg + IW'(1);
                if (pass_reg == IW'(N - 1)) begin
                    cnt_next = '0;
                    if (len_reg == '0) begin
                        sdone_next = 1'b0;
                        state_next = nlp_pkg::ST_SINGLE;
                    end else begin
                        state_next = nlp_pkg::ST_EMIT;
                    end
                end
            end
            nlp_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_sym_next   = cell_val[0];
                    m_pos_next   = nlp_pkg::POS_W'(cnt_reg);
                    m_last_next  = (cnt_inc == nemit);
                    m_done_next  = 1'b0;
                    m_empty_next = 1'b0;
                    m_ovf_next   = ovf_reg;
                    for (int k = 0; k < N; k++) begin
                        cell_ctl[k].op = nlp_pkg::CELL_FROM_RIGHT;
                    end
                    cnt_next = cnt_inc;
                    if (cnt_inc == nemit) begin
                        state_next = (cnt_inc == LW'(N)) ? nlp_pkg::ST_IDLE
                                                         : nlp_pkg::ST_RESTORE;
                    end
                end
            end
            nlp_pkg::ST_RESTORE: begin
                // finish the full turn so byte zero is back in cell zero
                for (int k = 0; k < N; k++) begin
                    cell_ctl[k].op = nlp_pkg::CELL_FROM_RIGHT;
                end
                cnt_next = cnt_inc;
                if (cnt_inc == LW'(N)) begin
                    state_next = nlp_pkg::ST_IDLE;
                end
            end
            nlp_pkg::ST_SINGLE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_sym_next   = '0;
                    m_pos_next   = '0;
                    m_last_next  = 1'b1;
                    m_done_next  = sdone_reg;
                    m_empty_next = (len_reg == '0);
                    m_ovf_next   = ovf_reg;
                    state_next   = nlp_pkg::ST_IDLE;
                end
            end
            default: state_next = nlp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= nlp_pkg::ST_IDLE;
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
        piv_reg     <= piv_next;
        pval_reg    <= pval_next;
        from_reg    <= from_next;
        pass_reg    <= pass_next;
        cnt_reg     <= cnt_next;
        sdone_reg   <= sdone_next;
        m_sym_reg   <= m_sym_next;
        m_pos_reg   <= m_pos_next;
        m_last_reg  <= m_last_next;
        m_done_reg  <= m_done_next;
        m_empty_reg <= m_empty_next;
        m_ovf_reg   <= m_ovf_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_symbol_out   = m_sym_reg;
    assign m_position     = m_pos_reg;
    assign m_is_last      = m_last_reg;
    assign m_done_res     = m_done_reg;
    assign m_string_empty = m_empty_reg;
    assign m_overflowed   = m_ovf_reg;

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LW'(N))
        else $error("string length beyond store size");

    a_ovf_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(ovf_reg) |-> len_reg == LW'(N))
        else $error("overflow flagged while store not full");

    a_emit_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == nlp_pkg::ST_EMIT |-> len_reg != '0)
        else $error("emitting bytes of an empty string");

    a_done_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_done_reg |-> m_last_reg && m_pos_reg == '0)
        else $error("done beat not a lone final beat");

    a_len_held: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == nlp_pkg::ST_SORT |=> len_reg == $past(len_reg))
        else $error("length changed during sort passes");

endmodule

// ===== sim/nlp_checker.sv =====
`timescale 1ns / 1ps
// nlp_checker: watches both channels of the permutation engine, keeps its own copy
// of the stored string, predicts every result beat and compares it field by field
// depends on nlp_pkg
module nlp_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [nlp_pkg::FUNC_W-1:0] s_func,
    input  logic [nlp_pkg::SYM_W-1:0]  s_symbol_in,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [nlp_pkg::SYM_W-1:0]  m_symbol_out,
    input  logic [nlp_pkg::POS_W-1:0]  m_position,
    input  logic                       m_is_last,
    input  logic                       m_done_res,
    input  logic                       m_string_empty,
    input  logic                       m_overflowed,
    output int                         mismatches,
    output int                         pending,
    output int                         cmds_seen,
    output int                         beats_checked,
    output int                         done_seen
);

    typedef struct packed {
        logic [nlp_pkg::SYM_W-1:0] sym;
        logic [nlp_pkg::POS_W-1:0] pos;
        logic                      last;
        logic                      done;
        logic                      empty;
        logic                      ovf;
    } perm_beat_t;

    logic [nlp_pkg::SYM_W-1:0] word_buf [nlp_pkg::MAX_LEN];
    int unsigned               word_len;
    logic                      ovf_seen;
    perm_beat_t                beats_due [$];

    function automatic void sort_tail(input int unsigned from);
        logic [nlp_pkg::SYM_W-1:0] tmp;
        for (int unsigned a = from; a + 1 < word_len; a++) begin
            for (int unsigned b = a + 1; b < word_len; b++) begin
                if (word_buf[b] < word_buf[a]) begin
                    tmp         = word_buf[a];
                    word_buf[a] = word_buf[b];
                    word_buf[b] = tmp;
                end
            end
        end
    endfunction

    // rightmost rise is the pivot, swap in the smallest larger byte to its right, then sort the bytes after it
    function automatic bit step_forward();
        int                        piv;
        int                        hi;
        logic [nlp_pkg::SYM_W-1:0] tmp;
        if (word_len < 2)
            return 1'b0;
        piv = int'(word_len) - 2;
        while (piv >= 0 && word_buf[piv] >= word_buf[piv+1])
            piv--;
        if (piv < 0)
            return 1'b0;
        hi = int'(word_len) - 1;
        while (word_buf[hi] <= word_buf[piv])
            hi--;
        tmp           = word_buf[piv];
        word_buf[piv] = word_buf[hi];
        word_buf[hi]  = tmp;
        sort_tail(piv + 1);
        return 1'b1;
    endfunction

    function automatic void push_beat(input logic [nlp_pkg::SYM_W-1:0] sym,
                                      input int unsigned pos,
                                      input logic last, input logic done);
        perm_beat_t b;
        b.sym   = sym;
        b.pos   = nlp_pkg::POS_W'(pos);
        b.last  = last;
        b.done  = done;
        b.empty = (word_len == 0);
        b.ovf   = ovf_seen;
        beats_due.push_back(b);
    endfunction

    function automatic void emit_string();
        int unsigned n;
        n = (word_len < nlp_pkg::EMIT_CAP) ? word_len : nlp_pkg::EMIT_CAP;
        if (n == 0)
            push_beat('0, 0, 1'b1, 1'b0);
        else
            for (int unsigned k = 0; k < n; k++)
                push_beat(word_buf[k], k, k + 1 == n, 1'b0);
    endfunction

    function automatic void absorb_cmd(input nlp_pkg::func_t f,
                                       input logic [nlp_pkg::SYM_W-1:0] sym);
        case (f)
            nlp_pkg::FUNC_CLEAR: begin
                word_len = 0;
                ovf_seen = 1'b0;
            end
            nlp_pkg::FUNC_APPEND: begin
                if (word_len < nlp_pkg::MAX_LEN) begin
                    word_buf[word_len] = sym;
                    word_len++;
                end else begin
                    ovf_seen = 1'b1;
                end
            end
            nlp_pkg::FUNC_SORT: begin
                sort_tail(0);
                emit_string();
            end
            default: begin
                if (step_forward())
                    emit_string();
                else
                    push_beat('0, 0, 1'b1, 1'b1);
            end
        endcase
    endfunction

    function automatic void check_field(input string fname,
                                        input logic [nlp_pkg::SYM_W-1:0] want_v,
                                        input logic [nlp_pkg::SYM_W-1:0] got_v);
        if (want_v !== got_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h",
                     $time, fname, want_v, got_v);
        end
    endfunction

    always @(posedge aclk) begin
        perm_beat_t want;
        if (!aresetn) begin
            word_len = 0;
            ovf_seen = 1'b0;
            beats_due.delete();
        end else begin
            if (s_valid && s_ready) begin
                absorb_cmd(nlp_pkg::func_t'(s_func), s_symbol_in);
                cmds_seen++;
            end
            if (m_valid && m_ready) begin
                if (beats_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat with nothing expected, sym %0h pos %0d",
                             $time, m_symbol_out, m_position);
                end else begin
                    want = beats_due.pop_front();
                    check_field("symbol_out", want.sym, m_symbol_out);
                    check_field("position", want.pos, m_position);
                    check_field("is_last", want.last, m_is_last);
                    check_field("done_res", want.done, m_done_res);
                    check_field("string_empty", want.empty, m_string_empty);
                    check_field("overflowed", want.ovf, m_overflowed);
                    beats_checked++;
                    if (want.done)
                        done_seen++;
                end
            end
        end
        pending = beats_due.size();
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// testbench: reset, directed and random command streams for the permutation engine
// with random stalls on both channels; depends on nlp_pkg, the engine and nlp_checker
module testbench;

    localparam int ITEM_TARGET  = 270;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 80;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic [nlp_pkg::FUNC_W-1:0] s_func;
    logic [nlp_pkg::SYM_W-1:0]  s_symbol_in;
    logic                       m_valid;
    logic                       m_ready;
    logic [nlp_pkg::SYM_W-1:0]  m_symbol_out;
    logic [nlp_pkg::POS_W-1:0]  m_position;
    logic                       m_is_last;
    logic                       m_done_res;
    logic                       m_string_empty;
    logic                       m_overflowed;

    int mismatches;
    int pending;
    int cmds_seen;
    int beats_checked;
    int done_seen;
    int cmds_sent;
    int cycles;
    int send_calm;
    int recv_calm;

    next_lexicographic_permutation dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_symbol_in    (s_symbol_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_symbol_out   (m_symbol_out),
        .m_position     (m_position),
        .m_is_last      (m_is_last),
        .m_done_res     (m_done_res),
        .m_string_empty (m_string_empty),
        .m_overflowed   (m_overflowed)
    );

    nlp_checker perm_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_symbol_in    (s_symbol_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_symbol_out   (m_symbol_out),
        .m_position     (m_position),
        .m_is_last      (m_is_last),
        .m_done_res     (m_done_res),
        .m_string_empty (m_string_empty),
        .m_overflowed   (m_overflowed),
        .mismatches     (mismatches),
        .pending        (pending),
        .cmds_seen      (cmds_seen),
        .beats_checked  (beats_checked),
        .done_seen      (done_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // mostly a random idle gap, with occasional runs of back-to-back traffic
    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 11) == 0) begin
            calm_left = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    function automatic logic [nlp_pkg::SYM_W-1:0] pick_symbol(
        input int style, input logic [nlp_pkg::SYM_W-1:0] base);
        case (style)
            0: return nlp_pkg::SYM_W'($urandom_range(0, 255));
            1: return base + nlp_pkg::SYM_W'($urandom_range(0, 2));
            2: begin
                case ($urandom_range(0, 3))
                    0: return 8'h00;
                    1: return 8'h7f;
                    2: return 8'h80;
                    default: return 8'hff;
                endcase
            end
            default: return nlp_pkg::SYM_W'($urandom_range(0, 3));
        endcase
    endfunction

    // entered and left at a falling edge with s_valid low
    task automatic send_cmd(input nlp_pkg::func_t f, input logic [nlp_pkg::SYM_W-1:0] sym);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0)
            repeat (gap) @(negedge aclk);
        s_valid     = 1'b1;
        s_func      = f;
        s_symbol_in = sym;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid = 1'b0;
        cmds_sent++;
    endtask

    task automatic wait_results_drained();
        while (pending != 0)
            @(negedge aclk);
    endtask

    // maybe clear, fill, maybe sort, then walk some permutations with a little noise mixed in
    task automatic run_sequence();
        int                        len;
        int                        steps;
        int                        style;
        logic [nlp_pkg::SYM_W-1:0] base;
        if ($urandom_range(0, 4) != 0)
            send_cmd(nlp_pkg::FUNC_CLEAR, nlp_pkg::SYM_W'($urandom_range(0, 255)));
        style = $urandom_range(0, 3);
        base  = nlp_pkg::SYM_W'($urandom_range(0, 255));
        len   = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 18) : $urandom_range(0, 5);
        for (int i = 0; i < len; i++)
            send_cmd(nlp_pkg::FUNC_APPEND, pick_symbol(style, base));
        if ($urandom_range(0, 3) != 0)
            send_cmd(nlp_pkg::FUNC_SORT, nlp_pkg::SYM_W'($urandom_range(0, 255)));
        steps = $urandom_range(1, 8);
        for (int i = 0; i < steps; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_cmd(nlp_pkg::func_t'($urandom_range(0, 3)),
                         nlp_pkg::SYM_W'($urandom_range(0, 255)));
            send_cmd(nlp_pkg::FUNC_NEXT, nlp_pkg::SYM_W'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 5) == 0)
            wait_results_drained();
    endtask

    initial begin
        int unused;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            unused = draw_gap(recv_calm);
            if (unused > 0) begin
                m_ready = 1'b0;
                repeat (unused) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_func      = nlp_pkg::FUNC_CLEAR;
        s_symbol_in = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty and one-byte strings, then a three-byte walk to the last order
        send_cmd(nlp_pkg::FUNC_SORT, 8'hff);
        send_cmd(nlp_pkg::FUNC_NEXT, 8'h00);
        send_cmd(nlp_pkg::FUNC_APPEND, 8'hff);
        send_cmd(nlp_pkg::FUNC_NEXT, 8'hff);
        send_cmd(nlp_pkg::FUNC_APPEND, 8'h00);
        send_cmd(nlp_pkg::FUNC_APPEND, 8'h80);
        send_cmd(nlp_pkg::FUNC_NEXT, 8'h55);
        send_cmd(nlp_pkg::FUNC_NEXT, 8'haa);
        // fill to capacity with repeats, then one byte too many
        for (int i = 0; i < nlp_pkg::MAX_LEN - 3; i++)
            send_cmd(nlp_pkg::FUNC_APPEND,
                     $urandom_range(0, 1) ? 8'h42 : nlp_pkg::SYM_W'($urandom_range(0, 255)));
        send_cmd(nlp_pkg::FUNC_APPEND, 8'h01);
        send_cmd(nlp_pkg::FUNC_SORT, 8'h00);
        send_cmd(nlp_pkg::FUNC_NEXT, 8'hff);
        send_cmd(nlp_pkg::FUNC_CLEAR, 8'hff);
        wait_results_drained();

        while (cmds_sent < ITEM_TARGET)
            run_sequence();

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("covered %0d commands, %0d result beats checked (%0d no-successor answers)",
                 cmds_seen, beats_checked, done_seen);
        $display("mismatches: %0d, beats still owed: %0d", mismatches, pending);
        if (mismatches == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/nlp_pkg.sv
src/nlp_cell.sv
src/next_lexicographic_permutation.sv
sim/nlp_checker.sv
sim/testbench.sv
